/* rtl/mt64_pkg.sv */
// ----------------------------------------------------------------------------
// mt64_pkg
// Constants, types and helper functions for the 64-bit Mersenne Twister
// generator.
// ----------------------------------------------------------------------------
package mt64_pkg;

  localparam int STATE_WORDS   = 312;
  localparam int MIDDLE_OFFSET = 156;
  localparam int ADDR_W        = $clog2(STATE_WORDS + 2);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [63:0]       word_t;

  localparam addr_t LAST_ADDR    = addr_t'(STATE_WORDS - 1);
  localparam addr_t IDX_TWIST    = addr_t'(STATE_WORDS);
  localparam addr_t IDX_UNSEEDED = addr_t'(STATE_WORDS + 1);
  localparam addr_t MID_ADDR     = addr_t'(MIDDLE_OFFSET);

  localparam word_t MATRIX_A     = 64'hB502_6F5A_A966_19E9;
  localparam word_t TEMPER_D     = 64'h5555_5555_5555_5555;
  localparam word_t TEMPER_B     = 64'h71D6_7FFF_EDA6_0000;
  localparam word_t TEMPER_C     = 64'hFFF7_EEE0_0000_0000;
  localparam word_t DEFAULT_SEED = 64'd5489;

  // 6364136223846793005 split into 32-bit halves
  localparam logic [31:0] SEED_MULT_LO = 32'h4C95_7F2D;
  localparam logic [31:0] SEED_MULT_HI = 32'h5851_F42D;

  localparam int TEMPER_U = 29;
  localparam int TEMPER_S = 17;
  localparam int TEMPER_T = 37;
  localparam int TEMPER_L = 43;
  localparam int SPLIT_R  = 31;

  // reduce a sum below twice the store depth into the store range
  function automatic addr_t wrap_addr(input logic [ADDR_W:0] sum);
    logic [ADDR_W:0] diff;
    diff = sum - (ADDR_W+1)'(STATE_WORDS);
    if (sum >= (ADDR_W+1)'(STATE_WORDS)) begin
      return diff[ADDR_W-1:0];
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ ((y >> TEMPER_U) & TEMPER_D);
    y = y ^ ((y << TEMPER_S) & TEMPER_B);
    y = y ^ ((y << TEMPER_T) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

  // one twist step: upper bits of the current word, lower bits of the next
  function automatic word_t twist_word(input word_t cur, input word_t nxt,
                                       input word_t mid);
    word_t x;
    word_t xa;
    x  = {cur[63:SPLIT_R], nxt[SPLIT_R-1:0]};
    xa = x >> 1;
    if (x[0]) begin
      xa = xa ^ MATRIX_A;
    end
    return mid ^ xa;
  endfunction

endpackage

/* rtl/mersenne_twister_64_generator.sv */
// ----------------------------------------------------------------------------
// mersenne_twister_64_generator
// MT19937-64 generator with its 312-word state in a two-read, one-write
// synchronous memory. A draw beat (mode 1) does one memory read, then
// tempers the word into the output register once that register is free.
// Every 312th draw first twists the store, one word per cycle through the
// memory's two read ports after the prime states PRIME0 and PRIME1. A seed
// beat (mode 0) gives no result: word 0 is written in the accepting cycle
// and the other 311 words are computed one after another on the shared
// 32x32 multiplier; a draw before any seed runs that seed with 5489 first.
// No new beat is taken until the last one is done. A finished word waits
// in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [63:0] seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_word
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SEED      = 6'b000010,
    ST_PRIME0    = 6'b000100,
    ST_PRIME1    = 6'b001000,
    ST_TWIST     = 6'b010000,
    ST_DRAW_RD   = 6'b100000
  } state_t;

  // the draw data cycle reuses the idle code space through a flag
  state_t                state;
  state_t                state_next;
  logic                  draw_wait;
  logic                  draw_pend;
  mt64_pkg::addr_t       read_index;
  mt64_pkg::addr_t       cnt;
  logic [1:0]            phase;
  mt64_pkg::word_t       prev;
  mt64_pkg::word_t       acc;
  mt64_pkg::word_t       cur;

  // word store
  mt64_pkg::word_t       mem [mt64_pkg::STATE_WORDS];
  logic                  we;
  mt64_pkg::addr_t       wa;
  mt64_pkg::word_t       wd;
  logic                  re_a;
  logic                  re_b;
  mt64_pkg::addr_t       ra;
  mt64_pkg::addr_t       rb;
  mt64_pkg::word_t       qa;
  mt64_pkg::word_t       qb;
  logic                  fwd_a;
  logic                  fwd_b;
  mt64_pkg::word_t       fwd_data;
  mt64_pkg::word_t       qa_eff;
  mt64_pkg::word_t       qb_eff;

  // seed multiplier
  mt64_pkg::word_t       seed_x;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_p;
  mt64_pkg::word_t       seed_word;
  mt64_pkg::word_t       tw_word;

  logic                  in_take;
  logic                  out_free;

  assign in_stall  = rst || (state != ST_IDLE) || draw_wait;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign qa_eff    = fwd_a ? fwd_data : qa;
  assign qb_eff    = fwd_b ? fwd_data : qb;

  assign seed_x    = prev ^ (prev >> 62);
  assign mul_a     = (phase == 2'd2) ? seed_x[63:32] : seed_x[31:0];
  assign mul_b     = (phase == 2'd1) ? mt64_pkg::SEED_MULT_HI : mt64_pkg::SEED_MULT_LO;
  assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
  assign seed_word = acc + {mul_p[31:0], 32'd0};
  assign tw_word   = mt64_pkg::twist_word(cur, qa_eff, qb_eff);

  // memory port control
  always_comb begin
    we   = 1'b0;
    wa   = '0;
    wd   = prev;
    re_a = 1'b0;
    re_b = 1'b0;
    ra   = '0;
    rb   = '0;
    case (state)
      ST_IDLE: begin
        if (in_take && !mode) begin
          we = 1'b1;
          wd = seed_value;
        end else if (in_take && read_index == mt64_pkg::IDX_UNSEEDED) begin
          we = 1'b1;
          wd = mt64_pkg::DEFAULT_SEED;
        end
      end
      ST_SEED: begin
        if (phase == 2'd2) begin
          we = 1'b1;
          wa = cnt;
          wd = seed_word;
        end
      end
      ST_PRIME0: begin
        re_a = 1'b1;
      end
      ST_PRIME1: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = mt64_pkg::addr_t'(1);
        rb   = mt64_pkg::wrap_addr({1'b0, mt64_pkg::MID_ADDR});
      end
      ST_TWIST: begin
        we   = 1'b1;
        wa   = cnt;
        wd   = tw_word;
        re_a = 1'b1;
        re_b = 1'b1;
        ra   = mt64_pkg::wrap_addr({1'b0, cnt} + (mt64_pkg::ADDR_W+1)'(2));
        rb   = mt64_pkg::wrap_addr({1'b0, cnt} + {1'b0, mt64_pkg::MID_ADDR}
                                   + (mt64_pkg::ADDR_W+1)'(1));
      end
      ST_DRAW_RD: begin
        re_a = 1'b1;
        ra   = read_index;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re_a) begin
      qa    <= mem[ra];
      fwd_a <= we && (ra == wa);
    end
    if (re_b) begin
      qb    <= mem[rb];
      fwd_b <= we && (rb == wa);
    end
    if (we) begin
      fwd_data <= wd;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (!mode || read_index == mt64_pkg::IDX_UNSEEDED) begin
            state_next = ST_SEED;
          end else if (read_index == mt64_pkg::IDX_TWIST) begin
            state_next = ST_PRIME0;
          end else begin
            state_next = ST_DRAW_RD;
          end
        end
      end
      ST_SEED: begin
        if (phase == 2'd2 && cnt == mt64_pkg::LAST_ADDR) begin
          state_next = draw_pend ? ST_PRIME0 : ST_IDLE;
        end
      end
      ST_PRIME0: state_next = ST_PRIME1;
      ST_PRIME1: state_next = ST_TWIST;
      ST_TWIST: begin
        if (cnt == mt64_pkg::LAST_ADDR) begin
          state_next = ST_DRAW_RD;
        end
      end
      ST_DRAW_RD: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      draw_wait  <= 1'b0;
      draw_pend  <= 1'b0;
      read_index <= mt64_pkg::IDX_UNSEEDED;
      cnt        <= '0;
      phase      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (draw_wait && out_free) begin
            // tempered word into the output register
            draw_wait   <= 1'b0;
            out_valid   <= 1'b1;
            random_word <= mt64_pkg::temper(qa_eff);
            read_index  <= read_index + mt64_pkg::addr_t'(1);
          end
          if (in_take) begin
            draw_pend <= mode;
            cnt       <= mt64_pkg::addr_t'(1);
            phase     <= '0;
            if (!mode) begin
              prev <= seed_value;
            end else begin
              prev <= mt64_pkg::DEFAULT_SEED;
            end
          end
        end
        ST_SEED: begin
          case (phase)
            2'd0: begin
              acc   <= mul_p + {{(64-mt64_pkg::ADDR_W){1'b0}}, cnt};
              phase <= 2'd1;
            end
            2'd1: begin
              acc   <= seed_word;
              phase <= 2'd2;
            end
            default: begin
              prev  <= seed_word;
              phase <= 2'd0;
              cnt   <= cnt + mt64_pkg::addr_t'(1);
              if (cnt == mt64_pkg::LAST_ADDR) begin
                read_index <= mt64_pkg::IDX_TWIST;
              end
            end
          endcase
        end
        ST_PRIME0: begin
          cnt <= '0;
        end
        ST_PRIME1: begin
          cur <= qa_eff;
        end
        ST_TWIST: begin
          cur <= qa_eff;
          cnt <= cnt + mt64_pkg::addr_t'(1);
          if (cnt == mt64_pkg::LAST_ADDR) begin
            read_index <= '0;
          end
        end
        ST_DRAW_RD: begin
          draw_wait <= 1'b1;
        end
        default: begin
          draw_wait <= 1'b0;
        end
      endcase
    end
  end

  // checks
  a_seed_phase: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEED |-> phase != 2'd3)
    else $error("seed phase out of range");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(draw_wait))
    else $error("result without a draw read");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    we |-> wa <= mt64_pkg::LAST_ADDR)
    else $error("store write out of range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    read_index <= mt64_pkg::IDX_UNSEEDED)
    else $error("read index out of range");

  a_draw_seeded: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAW_RD |-> read_index <= mt64_pkg::LAST_ADDR)
    else $error("draw from an unseeded or stale store");

endmodule

/* verif/mersenne_twister_64_generator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_twister_64_generator_tb
// Self-checking bench for the 64-bit Mersenne Twister. Seed and draw beats are
// driven through the valid/stall input channel. Each accepted beat is run
// through a behavioral copy of the generator, and every output beat is
// compared against the oldest predicted word. A short directed table comes
// first, then runs of a seed followed by draws, one of them long enough to
// force a twist, under changing amounts of idling and back-pressure.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator_tb;

  localparam logic  MODE_SEED    = 1'b0;
  localparam logic  MODE_DRAW    = 1'b1;
  localparam mt64_pkg::word_t SEED_MUL  = 64'd6364136223846793005;
  localparam mt64_pkg::word_t HIGH_BITS = 64'hFFFF_FFFF_8000_0000;
  localparam mt64_pkg::word_t LOW_BITS  = 64'h0000_0000_7FFF_FFFF;
  // first word out of a generator seeded with the default seed
  localparam mt64_pkg::word_t FIRST_DEFAULT_WORD = 64'd14514284786278117030;
  localparam int    N_DIRECTED   = 18;
  localparam int    RANDOM_BEATS = 450;
  localparam int    LONG_RUN     = 330;
  localparam int    HOLD_CYCLES  = 200;
  localparam int    DRAIN_CYCLES = 1200;

  typedef struct {
    logic            beat_mode;
    mt64_pkg::word_t beat_seed;
    logic            known;
    mt64_pkg::word_t known_word;
  } beat_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [63:0] seed_value;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] random_word;

  mt64_pkg::word_t gen_words [mt64_pkg::STATE_WORDS];
  int              gen_pos;
  mt64_pkg::word_t expected_words [$];
  mt64_pkg::word_t due_word;
  int        errors = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_ticket = 0;
  int        hold_seen = 0;
  beat_row_t directed_rows [N_DIRECTED];

  mersenne_twister_64_generator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------- generator model ----------------

  function automatic void seed_gen(input mt64_pkg::word_t s);
    int k;
    gen_words[0] = s;
    for (k = 1; k < mt64_pkg::STATE_WORDS; k++) begin
      gen_words[k] = SEED_MUL * (gen_words[k-1] ^ (gen_words[k-1] >> 62))
                     + mt64_pkg::word_t'(k);
    end
    gen_pos = mt64_pkg::STATE_WORDS;
  endfunction

  function automatic void twist_gen();
    int              k;
    mt64_pkg::word_t x;
    mt64_pkg::word_t xa;
    for (k = 0; k < mt64_pkg::STATE_WORDS; k++) begin
      x  = (gen_words[k] & HIGH_BITS)
           | (gen_words[(k + 1) % mt64_pkg::STATE_WORDS] & LOW_BITS);
      xa = x >> 1;
      if (x[0]) begin
        xa = xa ^ mt64_pkg::MATRIX_A;
      end
      gen_words[k] = gen_words[(k + mt64_pkg::MIDDLE_OFFSET) % mt64_pkg::STATE_WORDS] ^ xa;
    end
    gen_pos = 0;
  endfunction

  function automatic mt64_pkg::word_t draw_gen();
    mt64_pkg::word_t y;
    if (gen_pos >= mt64_pkg::STATE_WORDS) begin
      // store used up: twist, after seeding with the default seed if never seeded
      if (gen_pos > mt64_pkg::STATE_WORDS) begin
        seed_gen(mt64_pkg::DEFAULT_SEED);
      end
      twist_gen();
    end
    y = gen_words[gen_pos];
    y = y ^ ((y >> 29) & mt64_pkg::TEMPER_D);
    y = y ^ ((y << 17) & mt64_pkg::TEMPER_B);
    y = y ^ ((y << 37) & mt64_pkg::TEMPER_C);
    y = y ^ (y >> 43);
    gen_pos++;
    return y;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input mt64_pkg::word_t want,
                                 input mt64_pkg::word_t got);
    errors++;
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("random_word with nothing pending", '0, random_word);
      end else begin
        due_word = expected_words.pop_front();
        if (random_word !== due_word) begin
          report_mismatch("random_word", due_word, random_word);
        end
      end
    end
  end

  // ---------------- receiver ----------------

  initial begin
    int k;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        out_stall <= 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------- sender ----------------

  function automatic void set_idling(input int n);
    case ((n / 56) % 4)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct  = 68;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 68;
      end
      default: begin
        tx_idle_pct  = 35;
        rx_stall_pct = 35;
      end
    endcase
  endfunction

  task automatic send_beat(input logic m, input mt64_pkg::word_t s, input logic known,
                           input mt64_pkg::word_t known_word);
    mt64_pkg::word_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    seed_value <= s;
    do @(posedge clk); while (in_stall);
    if (m == MODE_DRAW) begin
      w = draw_gen();
      expected_words.push_back(known ? known_word : w);
    end else begin
      seed_gen(s);
    end
  endtask

  initial begin
    int              i;
    int              n;
    int              run_len;
    mt64_pkg::word_t s;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    mode       <= MODE_SEED;
    seed_value <= '0;
    gen_pos     = mt64_pkg::STATE_WORDS + 1;
    directed_rows = '{
      '{MODE_DRAW, 64'd0, 1'b1, FIRST_DEFAULT_WORD},  // draw before any seed
      '{MODE_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
      '{MODE_SEED, mt64_pkg::DEFAULT_SEED, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b1, FIRST_DEFAULT_WORD},  // reseed restarts the sequence
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_SEED, 64'd0, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_SEED, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
      '{MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},  // back-to-back seeds
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_DRAW, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
      '{MODE_SEED, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0},
      '{MODE_SEED, 64'd1, 1'b0, 64'd0},
      '{MODE_DRAW, 64'd0, 1'b0, 64'd0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_beat(directed_rows[i].beat_mode, directed_rows[i].beat_seed,
                directed_rows[i].known, directed_rows[i].known_word);
    end

    // runs of seed + draws; the first run is long enough to cross a twist
    n       = 0;
    run_len = LONG_RUN;
    while (n < RANDOM_BEATS) begin
      set_idling(n);
      s = {$urandom, $urandom};
      send_beat(MODE_SEED, s, 1'b0, '0);
      n++;
      if ($urandom_range(9) == 0) begin
        send_beat(MODE_SEED, {$urandom, $urandom}, 1'b0, '0);
        n++;
      end
      for (i = 0; i < run_len && n < RANDOM_BEATS; i++) begin
        set_idling(n);
        if (n == 130) begin
          hold_ticket++;
        end
        if (n == 250) begin
          // let everything drain before going on
          in_valid <= 1'b0;
          do @(posedge clk); while (expected_words.size() != 0);
        end
        if ($urandom_range(79) == 0) begin
          send_beat(MODE_SEED, {$urandom, $urandom}, 1'b0, '0);
        end else begin
          send_beat(MODE_DRAW, {$urandom, $urandom}, 1'b0, '0);
        end
        n++;
      end
      run_len = $urandom_range(50, 1);
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    // a trailing seed can still be running, watch for stray beats
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
